/* sv/mersenne_twister_ranged_draw_core_assert.svh */
// assertion macros for the twister core
`ifndef MERSENNE_TWISTER_RANGED_DRAW_CORE_ASSERT_SVH
`define MERSENNE_TWISTER_RANGED_DRAW_CORE_ASSERT_SVH

// implication that must hold at every edge out of reset
`define MTRD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define MTRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/mtrd_pkg.sv */
package mtrd_pkg;
    localparam int unsigned DEPTH      = 624;
    localparam int unsigned OFFSET     = 397;
    localparam int unsigned IDX_W      = 10;
    localparam int unsigned ADDR_W     = 10;
    localparam logic [31:0] DEF_SEED   = 32'd4357;
    localparam logic [31:0] SEED_MULT  = 32'd69069;
    localparam logic [31:0] TW_MATRIX  = 32'h9908b0df;
    localparam logic [31:0] TEMPER_B   = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C   = 32'hefc60000;
    localparam logic [IDX_W-1:0] IDX_USED     = IDX_W'(DEPTH);
    localparam logic [IDX_W-1:0] IDX_UNSEEDED = IDX_W'(DEPTH + 1);

    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    // request to the divider
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [30:0] divisor;
    } t_div_req;

    // answer of the divider
    typedef struct packed {
        logic        done;
        logic        busy;
        logic [30:0] rem;
    } t_div_rsp;

    function automatic logic [31:0] temper(input logic [31:0] a);
        logic [31:0] y;
        y = a ^ (a >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic [31:0] mix(input logic [31:0] hi, input logic [31:0] lo,
                                        input logic [31:0] far);
        logic [31:0] y;
        logic [31:0] r;
        y = {hi[31], lo[30:0]};
        r = far ^ (y >> 1);
        if (y[0]) begin
            r = r ^ TW_MATRIX;
        end
        return r;
    endfunction
endpackage

/* sv/mtrd_divider.sv */
module mtrd_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mtrd_pkg::t_div_req i_req,
    output mtrd_pkg::t_div_rsp o_rsp
);
    import mtrd_pkg::*;

    logic [31:0] r_quo;
    logic [31:0] r_rem;
    logic [30:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] n_trial;
    logic [32:0] n_diff;

    // one quotient bit a cycle, restoring
    always_comb begin
        n_trial = {r_rem, r_quo[31]};
        n_diff  = n_trial - {2'b00, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_div  <= i_req.divisor;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_quo <= {r_quo[30:0], 1'b0};
                if (!n_diff[32]) begin
                    r_rem <= n_diff[31:0];
                end else begin
                    r_rem <= n_trial[31:0];
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.busy = r_busy;
    assign o_rsp.rem  = r_rem[30:0];
endmodule

/* sv/mersenne_twister_ranged_draw_core.sv */
// Ranged draw from an MT19937 generator with multiplicative (69069) seeding.
// One request in, one answer out. A reseed walks the 624-word table once.
// A draw with a nonzero limit does one table read, then a 32-step restoring
// divider for the remainder. Every 624th draw (and the first after a reseed)
// first regenerates the table, three reads and one write per word through a
// single-port memory; an unseeded draw adds the seeding walk as well. A zero
// limit answers 0 with no table read or division. The output register frees
// the input side only once the answer has been taken.
module mersenne_twister_ranged_draw_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [31:0] i_seed,
    input  logic [30:0] i_limit,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [30:0] o_value
);
    import mtrd_pkg::*;
    `include "mersenne_twister_ranged_draw_core_assert.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_SEED, S_REG_RD0, S_REG_RD1, S_REG_RD2, S_REG_WR,
        S_TMP_RD, S_TMP_WT, S_DIV, S_OUT
    } t_state;

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;
    logic        n_we;
    logic [ADDR_W-1:0] n_addr;
    logic [31:0] n_wdata;

    t_state            r_state;
    logic [IDX_W-1:0]  r_idx;
    logic [ADDR_W-1:0] r_k;
    logic [31:0]       r_acc;
    logic [31:0]       r_hi;
    logic [31:0]       r_lo;
    logic [30:0]       r_limit;
    logic              r_regen;
    logic              r_valid;
    logic [30:0]       r_value;
    t_div_req          n_req;
    t_div_rsp          w_rsp;

    logic [ADDR_W-1:0] w_next;
    logic [ADDR_W-1:0] w_far;
    logic              w_acc;

    assign w_acc   = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || r_valid;
    assign o_valid = r_valid;
    assign o_value = r_value;

    // neighbours of word k, wrapped without a divider
    assign w_next = (r_k == ADDR_W'(DEPTH - 1)) ? '0 : r_k + ADDR_W'(1);
    assign w_far  = (r_k >= ADDR_W'(DEPTH - OFFSET)) ? r_k - ADDR_W'(DEPTH - OFFSET)
                                                     : r_k + ADDR_W'(OFFSET);

    // memory port controls
    always_comb begin
        n_we    = 1'b0;
        n_addr  = r_k;
        n_wdata = r_acc;
        unique case (r_state)
            S_SEED:    n_we = 1'b1;
            S_REG_RD1: n_addr = w_next;
            S_REG_RD2: n_addr = w_far;
            S_REG_WR: begin
                n_we    = 1'b1;
                n_wdata = mix(r_hi, r_lo, r_rdata);
            end
            S_TMP_RD:  n_addr = r_idx[ADDR_W-1:0];
            default:   n_addr = r_k;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_addr] <= n_wdata;
        end
        r_rdata <= r_mem[n_addr];
    end

    always_comb begin
        n_req.start    = (r_state == S_TMP_WT);
        n_req.dividend = temper(r_rdata);
        n_req.divisor  = r_limit;
    end

    mtrd_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (n_req),
        .o_rsp  (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= IDX_UNSEEDED;
            r_valid <= 1'b0;
            r_k     <= '0;
            r_regen <= 1'b0;
        end else begin
            if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_limit <= i_limit;
                        r_k     <= '0;
                        if (i_op == OP_RESEED) begin
                            r_acc   <= (i_seed == '0) ? DEF_SEED : i_seed;
                            r_regen <= 1'b0;
                            r_state <= S_SEED;
                        end else if (i_limit == '0) begin
                            r_value <= '0;
                            r_state <= S_OUT;
                        end else if (r_idx == IDX_UNSEEDED) begin
                            r_acc   <= DEF_SEED;
                            r_regen <= 1'b1;
                            r_state <= S_SEED;
                        end else if (r_idx == IDX_USED) begin
                            r_state <= S_REG_RD0;
                        end else begin
                            r_state <= S_TMP_RD;
                        end
                    end
                end
                // write word k, next is 69069 times it
                S_SEED: begin
                    r_acc <= r_acc * SEED_MULT;
                    if (r_k == ADDR_W'(DEPTH - 1)) begin
                        r_k   <= '0;
                        r_idx <= IDX_USED;
                        if (r_regen) begin
                            r_state <= S_REG_RD0;
                        end else begin
                            r_value <= '0;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_k <= r_k + ADDR_W'(1);
                    end
                end
                S_REG_RD0: r_state <= S_REG_RD1;
                S_REG_RD1: begin
                    r_hi    <= r_rdata;
                    r_state <= S_REG_RD2;
                end
                S_REG_RD2: begin
                    r_lo    <= r_rdata;
                    r_state <= S_REG_WR;
                end
                S_REG_WR: begin
                    if (r_k == ADDR_W'(DEPTH - 1)) begin
                        r_k     <= '0;
                        r_idx   <= '0;
                        r_state <= S_TMP_RD;
                    end else begin
                        r_k     <= r_k + ADDR_W'(1);
                        r_state <= S_REG_RD0;
                    end
                end
                S_TMP_RD: r_state <= S_TMP_WT;
                S_TMP_WT: begin
                    r_idx   <= r_idx + IDX_W'(1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_rsp.done) begin
                        r_value <= w_rsp.rem;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // word read for hi in S_REG_RD0 is addressed by r_k (default arm)
    `MTRD_ASSERT_IMP(a_stall_busy, i_clk, i_rst_n, r_state != S_IDLE, o_stall,
        "input taken while busy")
    `MTRD_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, r_state == S_TMP_RD,
        r_idx < IDX_USED, "temper read past table end")
    `MTRD_ASSERT_NEXT(a_div_start, i_clk, i_rst_n, r_state == S_TMP_WT,
        w_rsp.busy, "divider did not start")
    `MTRD_ASSERT_IMP(a_out_range, i_clk, i_rst_n, r_valid && r_limit != '0,
        r_value < r_limit || $past(r_state) != S_OUT, "remainder not below limit")
endmodule

/* test/tb_mersenne_twister_ranged_draw_core.sv */
`timescale 1ns / 1ps

module tb_mersenne_twister_ranged_draw_core;
    import mtrd_pkg::*;

    localparam int unsigned N_RANDOM    = 1330;
    localparam int unsigned STALL_LIMIT = 200000;
    localparam int unsigned DRAIN_WAIT  = 100;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_op;
    logic [31:0] i_seed;
    logic [30:0] i_limit;
    logic        o_valid;
    logic        i_stall;
    logic [30:0] o_value;

    // one request as the stimulus sees it
    typedef struct {
        logic        op;
        logic [31:0] seed;
        logic [30:0] limit;
        bit          known;     // expected answer typed in
        logic [30:0] answer;
    } t_req;

    // own copy of the generator state
    logic [31:0] twist_words [DEPTH];
    int unsigned word_ptr;

    logic [30:0] answer_queue [$];
    t_req        directed [$];
    int unsigned mismatches;
    int unsigned idle_cycles;

    mersenne_twister_ranged_draw_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_op    (i_op),
        .i_seed  (i_seed),
        .i_limit (i_limit),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_value (o_value)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    task automatic seed_words(input logic [31:0] s);
        twist_words[0] = s;
        for (int k = 1; k < DEPTH; k++) begin
            twist_words[k] = twist_words[k-1] * 32'd69069;
        end
        word_ptr = DEPTH;
    endtask

    function automatic logic [31:0] twist_pair(input logic [31:0] hi, input logic [31:0] lo,
                                               input logic [31:0] far);
        logic [31:0] y;
        logic [31:0] r;
        y = {hi[31], lo[30:0]};
        r = far ^ {1'b0, y[31:1]};
        if (y[0]) begin
            r = r ^ 32'h9908b0df;
        end
        return r;
    endfunction

    function automatic logic [31:0] tempered(input logic [31:0] a);
        logic [31:0] y;
        y = a ^ {11'd0, a[31:11]};
        y = y ^ ({y[24:0], 7'd0} & 32'h9d2c5680);
        y = y ^ ({y[16:0], 15'd0} & 32'hefc60000);
        y = y ^ {18'd0, y[31:18]};
        return y;
    endfunction

    // next answer of the generator for one request
    task automatic predict_draw(input logic op, input logic [31:0] s, input logic [30:0] lim,
                                output logic [30:0] ans);
        logic [31:0] y;
        ans = '0;
        if (op == OP_RESEED) begin
            seed_words((s == 32'd0) ? 32'd4357 : s);
        end else if (lim != '0) begin
            if (word_ptr >= DEPTH) begin
                if (word_ptr != DEPTH) seed_words(32'd4357);
                for (int k = 0; k < DEPTH; k++) begin
                    twist_words[k] = twist_pair(twist_words[k], twist_words[(k+1) % DEPTH],
                                                twist_words[(k+OFFSET) % DEPTH]);
                end
                word_ptr = 0;
            end
            y = tempered(twist_words[word_ptr]);
            word_ptr++;
            ans = 31'(y % {1'b0, lim});
        end
    endtask

    task automatic add_row(input logic op, input logic [31:0] s, input logic [30:0] lim,
                           input bit known, input logic [30:0] ans);
        t_req r;
        r.op = op; r.seed = s; r.limit = lim; r.known = known; r.answer = ans;
        directed.push_back(r);
    endtask

    // drive one request and wait for its acceptance
    task automatic send_req(input t_req r);
        logic [30:0] ans;
        int unsigned wait_n;
        wait_n = $urandom_range(0, 11) * ($urandom_range(0, 3) != 0);
        if (wait_n != 0) begin
            i_valid <= 1'b0;
            repeat (wait_n) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= r.op;
        i_seed  <= r.seed;
        i_limit <= r.limit;
        predict_draw(r.op, r.seed, r.limit, ans);
        if (r.known && ans !== r.answer) begin
            $display("%0t predictor disagrees with table: expected %0d got %0d",
                     $time, r.answer, ans);
            mismatches++;
        end
        answer_queue.push_back(r.known ? r.answer : ans);
        do @(posedge i_clk); while (o_stall);
    endtask

    // receiver: random stalls, checks each answer
    initial begin
        int unsigned hold;
        i_stall = 1'b1;
        @(posedge i_clk iff i_rst_n);
        forever begin
            hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            // accepted at this edge
            if (answer_queue.size() == 0) begin
                $display("%0t unexpected answer: expected none got %0d", $time, o_value);
                mismatches++;
            end else if (o_value !== answer_queue[0]) begin
                $display("%0t value mismatch: expected %0d got %0d",
                         $time, answer_queue[0], o_value);
                mismatches++;
                void'(answer_queue.pop_front());
            end else begin
                void'(answer_queue.pop_front());
            end
        end
    end

    // watchdog on cycles with no acceptance
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        t_req r;
        int unsigned pick;
        mismatches  = 0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_op    = OP_DRAW;
        i_seed  = '0;
        i_limit = '0;
        for (int k = 0; k < DEPTH; k++) twist_words[k] = '0;
        word_ptr = DEPTH + 1;

        // zero limit before seeding, then unseeded draw, limit 1 always 0
        add_row(OP_DRAW,   32'hffffffff, 31'd0,          1, 31'd0);
        add_row(OP_DRAW,   32'd0,        31'h7fffffff,   0, 31'd0);
        add_row(OP_DRAW,   32'd0,        31'd1,          1, 31'd0);
        add_row(OP_DRAW,   32'h12345678, 31'd0,          1, 31'd0);
        add_row(OP_DRAW,   32'd0,        31'd2,          0, 31'd0);
        // reseeds answer 0, zero seed takes the default
        add_row(OP_RESEED, 32'd0,        31'h7fffffff,   1, 31'd0);
        add_row(OP_DRAW,   32'd0,        31'h7fffffff,   0, 31'd0);
        add_row(OP_RESEED, 32'hffffffff, 31'd0,          1, 31'd0);
        add_row(OP_DRAW,   32'd0,        31'h7fffffff,   0, 31'd0);
        add_row(OP_DRAW,   32'hffffffff, 31'd1,          1, 31'd0);
        add_row(OP_RESEED, 32'd1,        31'd5,          1, 31'd0);
        add_row(OP_DRAW,   32'd0,        31'd3,          0, 31'd0);
        add_row(OP_DRAW,   32'd0,        31'h40000000,   0, 31'd0);
        add_row(OP_RESEED, 32'h80000000, 31'd0,          1, 31'd0);
        add_row(OP_DRAW,   32'd0,        31'h55555555,   0, 31'd0);
        add_row(OP_DRAW,   32'd0,        31'h2aaaaaaa,   0, 31'd0);
        add_row(OP_DRAW,   32'd0,        31'd0,          1, 31'd0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[n]) send_req(directed[n]);

        // random part: mostly draws, reseeds in 4 of 100 picks
        for (int n = 0; n < N_RANDOM; n++) begin
            pick = $urandom_range(0, 99);
            r.known = 0;
            r.answer = '0;
            r.seed = $urandom();
            r.op = (pick < 4) ? OP_RESEED : OP_DRAW;
            if (pick == 4) r.seed = '0;
            if (pick >= 5 && pick < 9) r.limit = '0;
            else if (pick < 30) r.limit = 31'($urandom_range(1, 16));
            else r.limit = 31'($urandom());
            send_req(r);
        end
        i_valid <= 1'b0;

        while (answer_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+sv
sv/mtrd_pkg.sv
sv/mtrd_divider.sv
sv/mersenne_twister_ranged_draw_core.sv
test/tb_mersenne_twister_ranged_draw_core.sv
